>>> src/sbs_pkg.sv
// sbs_pkg: shared constants, codes and item types for the sorted bound search block
// no dependencies; imported by every module of the block except the generic ram
package sbs_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int POS_W  = ADDR_W + 2;
    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_LEFT  = 2'd1;
    localparam logic [1:0] ACT_RIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    found;
    } t_out_item;

    // result of one probe compare
    typedef struct packed {
        logic go_left;
        logic equal;
    } t_cmp_res;

endpackage

>>> src/sbs_ram.sv
// sbs_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sbs_cmp.sv
// sbs_cmp: shared signed compare unit used by every probe and the final equality check
// depends on sbs_pkg
module sbs_cmp (
    input  logic signed [sbs_pkg::DATA_W-1:0] i_value,
    input  logic signed [sbs_pkg::DATA_W-1:0] i_key,
    input  logic                              i_left,
    output sbs_pkg::t_cmp_res                 o_res
);
    import sbs_pkg::*;

    // leftmost moves left on value >= key, rightmost only on value > key
    always_comb begin
        o_res.equal   = (i_value == i_key);
        o_res.go_left = i_left ? (i_value >= i_key) : (i_value > i_key);
    end

endmodule

>>> src/sorted_bound_search.sv
// sorted_bound_search: top level with the probe sequencer, table ram and output register
// depends on sbs_pkg, sbs_ram, sbs_cmp
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries write and search items.
//   A write item stores entry_value at entry_index and leaves the sequencer idle; it gives
//   no result. A search item runs a binary search over the first active_length entries
//   (clamped to the table depth): each probe is one ram read in ST_PROBE and one compare
//   in the shared compare unit in ST_COMPARE (up to 11 probes for 1024 entries), and the
//   input channel stalls until the result has gone to the output register and the
//   sequencer is back in idle. Action code 3 is dropped.
//   Output channel (o_out_valid / i_out_stall / o_out_item) holds one result in a
//   register; a new item is taken while that result waits, and a finished search
//   waits in its last state until the output register is free.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes active_length; it
//   is always ready and should be written only while the block is idle.
//   Reset clears active_length, the sequencer and the output valid; the table is
//   undefined until written and takes no clearing pass.
module sorted_bound_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sbs_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sbs_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sbs_pkg::LEN_W-1:0]  i_cfg_data
);
    import sbs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_PROBE   = 5'b00010,
        ST_COMPARE = 5'b00100,
        ST_CHECK   = 5'b01000,
        ST_HOLD    = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [LEN_W-1:0]         r_active_length;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;

    logic [LEN_W-1:0]         r_len, n_len;
    logic [LEN_W-1:0]         r_lo, n_lo;
    logic signed [POS_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]        r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_left, n_left;
    logic signed [POS_W-1:0]  r_pos, n_pos;
    logic                     r_in_range, n_in_range;
    t_out_item                r_res, n_res;

    logic                     in_accept;
    logic                     out_free;
    logic [LEN_W-1:0]         len_clamped;
    logic signed [POS_W-1:0]  lo_ext;
    logic                     searching;
    logic [POS_W-1:0]         mid_sum;
    logic signed [POS_W-1:0]  final_pos;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     ram_we;
    t_cmp_res                 cmp_res;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign len_clamped = (r_active_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : r_active_length;
    assign lo_ext      = signed'({1'b0, r_lo});
    assign searching   = (lo_ext <= r_hi);
    // both bounds are non-negative while searching, so the midpoint is the halved sum
    assign mid_sum     = {1'b0, r_lo} + {2'b00, r_hi[ADDR_W-1:0]};
    assign final_pos   = r_left ? lo_ext : r_hi;
    assign ram_we      = in_accept && (i_in_item.action == ACT_WRITE);
    assign ram_raddr   = searching ? mid_sum[ADDR_W:1] : final_pos[ADDR_W-1:0];

    sbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_item.entry_index),
        .i_wdata (i_in_item.entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sbs_cmp u_cmp (
        .i_value (signed'(ram_rdata)),
        .i_key   (r_key),
        .i_left  (r_left),
        .o_res   (cmp_res)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_left      = r_left;
        n_pos       = r_pos;
        n_in_range  = r_in_range;
        n_res       = r_res;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_in_item.action == ACT_LEFT ||
                                  i_in_item.action == ACT_RIGHT)) begin
                    n_key   = i_in_item.search_key;
                    n_left  = (i_in_item.action == ACT_LEFT);
                    n_len   = len_clamped;
                    n_lo    = '0;
                    n_hi    = signed'({1'b0, len_clamped}) - POS_W'(1);
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (searching) begin
                    n_mid   = mid_sum[ADDR_W:1];
                    n_state = ST_COMPARE;
                end else begin
                    n_pos      = final_pos;
                    n_in_range = (final_pos >= 0) && (final_pos < signed'({1'b0, r_len}));
                    n_state    = ST_CHECK;
                end
            end
            ST_COMPARE: begin
                if (cmp_res.go_left) begin
                    n_hi = signed'({2'b00, r_mid}) - POS_W'(1);
                end else begin
                    n_lo = {1'b0, r_mid} + LEN_W'(1);
                end
                n_state = ST_PROBE;
            end
            ST_CHECK: begin
                n_res.position = r_pos;
                n_res.found    = r_in_range && cmp_res.equal;
                n_state        = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_active_length <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_len      <= n_len;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_key      <= n_key;
        r_left     <= n_left;
        r_pos      <= n_pos;
        r_in_range <= n_in_range;
        r_res      <= n_res;
    end

`ifndef ASSERT_OFF
    // a search item keeps the input stalled on the next cycle
    a_search_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.action == ACT_LEFT || i_in_item.action == ACT_RIGHT))
        |=> o_in_stall)
        else $error("search item did not stall the input");

    // the probed index stays inside the current bounds
    a_mid_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPARE) |->
        (lo_ext <= signed'({2'b00, r_mid})) && (signed'({2'b00, r_mid}) <= r_hi))
        else $error("probe index outside search bounds");

    // a found result always points at a real entry
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.found) |->
        (o_out_item.position >= 0) && (o_out_item.position < POS_W'(DEPTH)))
        else $error("found flag with position outside the table");
`endif

endmodule
